FILE: rtl/core/fis_pkg.sv
// ----------------------------------------------------------------------------
// fis_pkg
// Shared types, widths and helper functions for the frame interval smoother.
// ----------------------------------------------------------------------------
package fis_pkg;

    // Fixed-point and counter sizing
    localparam int FRAC_BITS   = 8;
    localparam int COUNT_WIDTH = 16;

    // Field widths
    localparam int TS_W     = 63;
    localparam int RAW_W    = 32;
    localparam int SMOOTH_W = 40;
    localparam int SUM_W    = 40;
    localparam int RATE_W   = 24;
    localparam int GAIN_W   = 8;
    localparam int GAIN_FRAC = 8;
    localparam int PROD_W   = SMOOTH_W + GAIN_W;

    // Rate division operands
    localparam int NUM_W       = COUNT_WIDTH + RAW_W;
    localparam int DIVIDEND_W  = NUM_W + FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

    // Configuration port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;

    localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = '1;
    localparam logic [SUM_W-1:0]    SUM_MAX    = '1;
    localparam logic [RATE_W-1:0]   RATE_MAX   = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        REG_TICK_RATE        = 3'd0,
        REG_MAX_INTERVAL     = 3'd1,
        REG_RELOAD_THRESHOLD = 3'd2,
        REG_FAST_THRESHOLD   = 3'd3,
        REG_FAST_GAIN        = 3'd4,
        REG_SLOW_GAIN        = 3'd5,
        REG_STATS_WINDOW     = 3'd6,
        REG_INITIAL_INTERVAL = 3'd7
    } fis_reg_idx_t;

    typedef struct packed {
        logic [RAW_W-1:0]  tick_rate;
        logic [RAW_W-1:0]  max_interval;
        logic [RAW_W-1:0]  reload_threshold;
        logic [RAW_W-1:0]  fast_threshold;
        logic [GAIN_W-1:0] fast_gain;
        logic [GAIN_W-1:0] slow_gain;
        logic [RAW_W-1:0]  stats_window;
        logic [RAW_W-1:0]  initial_interval;
    } fis_cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fis_div_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MULT,
        ST_STEP,
        ST_DIV,
        ST_EMIT
    } fis_state_t;

    // Ticks to Q32.FRAC_BITS, saturating at the smoothed field's maximum.
    function automatic logic [SMOOTH_W-1:0] to_q(input logic [RAW_W-1:0] ticks);
        logic [63:0] wide;
        wide = 64'(ticks) << FRAC_BITS;
        return (wide > 64'(SMOOTH_MAX)) ? SMOOTH_MAX : wide[SMOOTH_W-1:0];
    endfunction

endpackage

FILE: rtl/core/fis_regs.sv
// ----------------------------------------------------------------------------
// fis_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module fis_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fis_pkg::ADDR_W-1:0] paddr,
    input  logic [fis_pkg::DATA_W-1:0] pwdata,
    output logic [fis_pkg::DATA_W-1:0] prdata,
    output fis_pkg::fis_cfg_t          cfg
);
    import fis_pkg::*;

    fis_cfg_t     cfg_reg;
    fis_reg_idx_t idx;
    logic         wr_en;

    assign idx   = fis_reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_rate        <= 32'd10000000;
            cfg_reg.max_interval     <= 32'd1000000;
            cfg_reg.reload_threshold <= 32'd500000;
            cfg_reg.fast_threshold   <= 32'd83333;
            cfg_reg.fast_gain        <= 8'd46;
            cfg_reg.slow_gain        <= 8'd82;
            cfg_reg.stats_window     <= 32'd5000000;
            cfg_reg.initial_interval <= 32'd166667;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TICK_RATE:        cfg_reg.tick_rate        <= pwdata;
                REG_MAX_INTERVAL:     cfg_reg.max_interval     <= pwdata;
                REG_RELOAD_THRESHOLD: cfg_reg.reload_threshold <= pwdata;
                REG_FAST_THRESHOLD:   cfg_reg.fast_threshold   <= pwdata;
                REG_FAST_GAIN:        cfg_reg.fast_gain        <= pwdata[GAIN_W-1:0];
                REG_SLOW_GAIN:        cfg_reg.slow_gain        <= pwdata[GAIN_W-1:0];
                REG_STATS_WINDOW:     cfg_reg.stats_window     <= pwdata;
                REG_INITIAL_INTERVAL: cfg_reg.initial_interval <= pwdata;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TICK_RATE:        prdata = cfg_reg.tick_rate;
            REG_MAX_INTERVAL:     prdata = cfg_reg.max_interval;
            REG_RELOAD_THRESHOLD: prdata = cfg_reg.reload_threshold;
            REG_FAST_THRESHOLD:   prdata = cfg_reg.fast_threshold;
            REG_FAST_GAIN:        prdata = DATA_W'(cfg_reg.fast_gain);
            REG_SLOW_GAIN:        prdata = DATA_W'(cfg_reg.slow_gain);
            REG_STATS_WINDOW:     prdata = cfg_reg.stats_window;
            REG_INITIAL_INTERVAL: prdata = cfg_reg.initial_interval;
            default:              prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/fis_divider.sv
// ----------------------------------------------------------------------------
// fis_divider
// Restoring long divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fis_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [fis_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [fis_pkg::SUM_W-1:0]        divisor,
    output logic [fis_pkg::DIVIDEND_W-1:0]   quotient,
    output fis_pkg::fis_div_status_t         status
);
    import fis_pkg::*;

    logic [DIVIDEND_W-1:0] dq_reg, dq_next;
    logic [SUM_W-1:0]      rem_reg, rem_next;
    logic [SUM_W-1:0]      dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [SUM_W:0]        trial;
    logic [SUM_W:0]        diff;
    logic                  fits;

    // The partial remainder is shifted one dividend bit at a time.
    assign trial = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            dq_next  = {dq_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = dq_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

FILE: rtl/core/frame_interval_smoother.sv
// ----------------------------------------------------------------------------
// frame_interval_smoother
// Smooths frame-to-frame timer intervals and measures the frame rate.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  in       to block   in_valid / in_stall    timestamp (63 bit)
//  out      from block out_valid / out_stall  raw_interval, smoothed_interval,
//                                             frame_rate, rate_updated
//  cfg      to block   psel/penable/pwrite    paddr, pwdata, prdata, pready
//
//  A transaction without a rate update passes through DIFF, MULT, STEP
//  and EMIT (a priming one skips MULT and STEP) and is loaded into the
//  result register on leaving EMIT; the next one can be accepted in the
//  following cycle. When the interval sum reaches the window and is not
//  zero, the transaction also waits in DIV for the serial divider.
//  in_stall is high from acceptance until the result has been loaded into
//  the output register, which then waits for out_stall to fall while the
//  next transaction is already being worked on.
//  Reset clears control, smoothing and rate state; config takes defaults.
//
// The first transaction after reset primes the block: it stores the
// timestamp and reports initial_interval as both raw and smoothed values.
// Later transactions form the clamped raw interval, update the Q32.8
// smoothed interval by an exponential step (or reload it), and accumulate
// the statistics from which the Q16.8 frame rate is derived.
// ----------------------------------------------------------------------------
module frame_interval_smoother (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [fis_pkg::TS_W-1:0]    timestamp,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [fis_pkg::RAW_W-1:0]   raw_interval,
    output logic [fis_pkg::SMOOTH_W-1:0] smoothed_interval,
    output logic [fis_pkg::RATE_W-1:0]  frame_rate,
    output logic                        rate_updated,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fis_pkg::ADDR_W-1:0]  paddr,
    input  logic [fis_pkg::DATA_W-1:0]  pwdata,
    output logic [fis_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import fis_pkg::*;

    fis_cfg_t        cfg;
    fis_div_status_t div_status;
    logic [DIVIDEND_W-1:0] div_quotient;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic                  div_start;

    fis_state_t state_reg, state_next;

    // Control registers
    logic primed_reg, primed_next;
    logic out_valid_reg, out_valid_next;

    // Working registers
    logic [TS_W-1:0]        ts_reg, ts_next;
    logic [TS_W-1:0]        last_ts_reg, last_ts_next;
    logic [RAW_W-1:0]       raw_reg, raw_next;
    logic [SMOOTH_W-1:0]    smooth_reg, smooth_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [RATE_W-1:0]      rate_reg, rate_next;
    logic                   updated_reg, updated_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic                   up_reg, up_next;
    logic                   reload_reg, reload_next;

    // Result register
    logic [RAW_W-1:0]    out_raw_reg, out_raw_next;
    logic [SMOOTH_W-1:0] out_smooth_reg, out_smooth_next;
    logic [RATE_W-1:0]   out_rate_reg, out_rate_next;
    logic                out_updated_reg, out_updated_next;

    // Datapath terms
    logic                   in_accept;
    logic                   emit_go;
    logic [TS_W-1:0]        ts_diff;
    logic [RAW_W-1:0]       raw_clamped;
    logic [SMOOTH_W-1:0]    raw_q;
    logic [SMOOTH_W-1:0]    mag;
    logic [GAIN_W-1:0]      gain;
    logic [SUM_W:0]         sum_wide;
    logic [PROD_W:0]        step_dn_wide;
    logic                   rate_due;
    logic [NUM_W-1:0]       num;

    fis_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    fis_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (sum_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    assign pready    = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign emit_go   = !out_valid_reg || !out_stall;

    // Raw interval: zero when time runs backwards, clamped to max_interval.
    assign ts_diff     = (ts_reg >= last_ts_reg) ? (ts_reg - last_ts_reg) : '0;
    assign raw_clamped = (ts_diff > TS_W'(cfg.max_interval)) ? cfg.max_interval
                                                             : ts_diff[RAW_W-1:0];
    assign raw_q       = to_q(raw_reg);

    // Smoothing step operands: magnitude of the error times the chosen gain.
    assign mag  = (raw_q >= smooth_reg) ? (raw_q - smooth_reg) : (smooth_reg - raw_q);
    assign gain = (raw_reg <= cfg.fast_threshold) ? cfg.fast_gain : cfg.slow_gain;

    // Downward steps round toward minus infinity, hence the added bias.
    assign step_dn_wide = {1'b0, prod_reg} + (PROD_W + 1)'((1 << GAIN_FRAC) - 1);

    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(raw_reg);
    assign rate_due = sum_reg >= SUM_W'(cfg.stats_window);

    // Frame rate in Q16.8 is (count * tick_rate << FRAC_BITS) / sum.
    assign num          = NUM_W'(count_reg) * NUM_W'(cfg.tick_rate);
    assign div_dividend = {num, FRAC_BITS'(0)};
    assign div_start    = (state_reg == ST_STEP) && rate_due && (sum_reg != '0);

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                state_next = primed_reg ? ST_MULT : ST_EMIT;
            end
            ST_MULT:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                state_next = div_start ? ST_DIV : ST_EMIT;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer: datapath and result updates
    always_comb
    begin
        primed_next      = primed_reg;
        ts_next          = ts_reg;
        last_ts_next     = last_ts_reg;
        raw_next         = raw_reg;
        smooth_next      = smooth_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        rate_next        = rate_reg;
        updated_next     = updated_reg;
        prod_next        = prod_reg;
        up_next          = up_reg;
        reload_next      = reload_reg;
        out_raw_next     = out_raw_reg;
        out_smooth_next  = out_smooth_reg;
        out_rate_next    = out_rate_reg;
        out_updated_next = out_updated_reg;
        out_valid_next   = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    ts_next = timestamp;
                end
            end
            ST_DIFF:
            begin
                last_ts_next = ts_reg;
                updated_next = 1'b0;
                if (!primed_reg)
                begin
                    // Priming transaction: statistics are left alone.
                    primed_next = 1'b1;
                    raw_next    = cfg.initial_interval;
                    smooth_next = to_q(cfg.initial_interval);
                end
                else
                begin
                    raw_next = raw_clamped;
                end
            end
            ST_MULT:
            begin
                reload_next = (raw_reg >= cfg.reload_threshold) || (smooth_reg == '0);
                up_next     = raw_q >= smooth_reg;
                prod_next   = PROD_W'(mag) * PROD_W'(gain);
                sum_next    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_STEP:
            begin
                if (reload_reg)
                begin
                    smooth_next = raw_q;
                end
                else if (up_reg)
                begin
                    smooth_next = smooth_reg + SMOOTH_W'(prod_reg >> GAIN_FRAC);
                end
                else
                begin
                    smooth_next = smooth_reg - SMOOTH_W'(step_dn_wide >> GAIN_FRAC);
                end
                if (rate_due && (sum_reg == '0))
                begin
                    // An empty window gives a rate of zero.
                    rate_next    = '0;
                    sum_next     = '0;
                    count_next   = '0;
                    updated_next = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    rate_next = (div_quotient > DIVIDEND_W'(RATE_MAX))
                              ? RATE_MAX : div_quotient[RATE_W-1:0];
                    sum_next     = '0;
                    count_next   = '0;
                    updated_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next   = 1'b1;
                    out_raw_next     = raw_reg;
                    out_smooth_next  = smooth_reg;
                    out_rate_next    = rate_reg;
                    out_updated_next = updated_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            last_ts_reg   <= '0;
            smooth_reg    <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            rate_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            primed_reg    <= primed_next;
            out_valid_reg <= out_valid_next;
            last_ts_reg   <= last_ts_next;
            smooth_reg    <= smooth_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            rate_reg      <= rate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ts_reg          <= ts_next;
        raw_reg         <= raw_next;
        updated_reg     <= updated_next;
        prod_reg        <= prod_next;
        up_reg          <= up_next;
        reload_reg      <= reload_next;
        out_raw_reg     <= out_raw_next;
        out_smooth_reg  <= out_smooth_next;
        out_rate_reg    <= out_rate_next;
        out_updated_reg <= out_updated_next;
    end

    assign out_valid         = out_valid_reg;
    assign raw_interval      = out_raw_reg;
    assign smoothed_interval = out_smooth_reg;
    assign frame_rate        = out_rate_reg;
    assign rate_updated      = out_updated_reg;

    // Once primed, the block stays primed until the next reset.
    a_primed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg |=> primed_reg)
        else $error("primed flag dropped");

    // The divider is never started on an empty window.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (sum_reg != '0))
        else $error("rate division started with zero divisor");

    // A division completes only while the sequencer is waiting on it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the division state");

    // An accepted transaction closes the input until its result is loaded.
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input reopened right after acceptance");

endmodule

FILE: bench/frame_interval_smoother_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_interval_smoother_test
// Self-checking bench for the frame interval smoother. A directed table opens
// the run and walks the priming transaction, backwards time, clamping,
// reloads, both gains, the rate window and its saturating corners. Random
// phases with fresh register settings follow. Every result is compared
// field by field against a value typed into the table or, otherwise, a
// bench-side model of the smoothing and rate arithmetic.
// ----------------------------------------------------------------------------
module frame_interval_smoother_test;

    import fis_pkg::*;

    // Timing of the run.
    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 8;
    // The slowest transaction runs a rate division, plus stalls on both sides;
    // the long receiver hold-off is LONG_HOLD. The limit is several times both.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int LONG_HOLD       = 400;
    localparam int DRAIN_CYCLES    = 80;
    localparam int MAX_REPORTS     = 40;

    // One result transaction as the block presents it.
    typedef struct {
        logic [RAW_W-1:0]    raw;
        logic [SMOOTH_W-1:0] smooth;
        logic [RATE_W-1:0]   rate;
        logic                updated;
    } frame_result_t;

    // One row of the directed table: either a register write or a frame.
    // Rows with typed set carry an expectation written out by hand.
    typedef struct {
        bit                is_setting;
        fis_reg_idx_t      sel;
        logic [TS_W-1:0]   value;
        bit                typed;
        frame_result_t     want;
    } stimulus_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [TS_W-1:0]      timestamp;
    logic                 out_valid;
    logic                 out_stall;
    logic [RAW_W-1:0]     raw_interval;
    logic [SMOOTH_W-1:0]  smoothed_interval;
    logic [RATE_W-1:0]    frame_rate;
    logic                 rate_updated;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    // Bench-side copy of the block's registers and state.
    fis_cfg_t             model_cfg;
    bit                   seen_first  = 1'b0;
    logic [TS_W-1:0]      prev_stamp  = '0;
    logic [63:0]          smooth_acc  = '0;
    logic [63:0]          tick_sum    = '0;
    logic [63:0]          frame_tally = '0;
    logic [63:0]          rate_hold   = '0;

    frame_result_t        expected_frames[$];
    stimulus_row_t        directed_rows[$];
    logic [TS_W-1:0]      stamp_now = '0;
    int                   mismatch_count = 0;
    int                   results_checked = 0;
    int                   quiet_cycles = 0;
    // Shared between the sender and the receiver: no_idle switches off the
    // random bursts, hold_pending asks the receiver for one long hold-off.
    bit                   no_idle = 1'b0;
    bit                   hold_pending = 1'b0;

    frame_interval_smoother DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .timestamp         (timestamp),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .raw_interval      (raw_interval),
        .smoothed_interval (smoothed_interval),
        .frame_rate        (frame_rate),
        .rate_updated      (rate_updated),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------------

    // Register values that the block holds straight after reset.
    function automatic fis_cfg_t reset_settings();
        fis_cfg_t c;
        c.tick_rate        = 32'd10000000;
        c.max_interval     = 32'd1000000;
        c.reload_threshold = 32'd500000;
        c.fast_threshold   = 32'd83333;
        c.fast_gain        = 8'd46;
        c.slow_gain        = 8'd82;
        c.stats_window     = 32'd5000000;
        c.initial_interval = 32'd166667;
        return c;
    endfunction

    initial model_cfg = reset_settings();

    // Ticks to Q32.FRAC_BITS, saturating at the width of the smoothed field.
    function automatic logic [63:0] ticks_to_q(logic [63:0] ticks);
        logic [63:0] q;
        q = ticks << FRAC_BITS;
        return (q > 64'(SMOOTH_MAX)) ? 64'(SMOOTH_MAX) : q;
    endfunction

    // Advances the model by one accepted frame and returns its result.
    function automatic frame_result_t smoother_predict(logic [TS_W-1:0] ts);
        frame_result_t r;
        logic [63:0]   diff;
        logic [63:0]   raw;
        logic [63:0]   raw_q;
        logic [63:0]   gain;
        logic [63:0]   num;
        logic [63:0]   whole;
        logic [63:0]   rem;
        logic [63:0]   frac;
        r.updated = 1'b0;
        if (!seen_first)
        begin
            // The priming frame records the time and loads the initial interval.
            seen_first = 1'b1;
            prev_stamp = ts;
            raw        = 64'(model_cfg.initial_interval);
            smooth_acc = ticks_to_q(raw);
        end
        else
        begin
            diff       = (ts >= prev_stamp) ? 64'(ts - prev_stamp) : 64'd0;
            prev_stamp = ts;
            raw        = (diff > 64'(model_cfg.max_interval)) ?
                         64'(model_cfg.max_interval) : diff;
            raw_q      = ticks_to_q(raw);
            if (raw >= 64'(model_cfg.reload_threshold) || smooth_acc == 64'd0)
            begin
                smooth_acc = raw_q;
            end
            else
            begin
                gain = (raw <= 64'(model_cfg.fast_threshold)) ?
                       64'(model_cfg.fast_gain) : 64'(model_cfg.slow_gain);
                // The step rounds toward minus infinity in both directions.
                if (raw_q >= smooth_acc)
                    smooth_acc = smooth_acc + (((raw_q - smooth_acc) * gain) >> GAIN_FRAC);
                else
                    smooth_acc = smooth_acc - (((smooth_acc - raw_q) * gain
                                 + ((64'd1 << GAIN_FRAC) - 64'd1)) >> GAIN_FRAC);
            end

            tick_sum = tick_sum + raw;
            if (tick_sum > 64'(SUM_MAX))
                tick_sum = 64'(SUM_MAX);
            if (frame_tally < 64'(COUNT_MAX))
                frame_tally = frame_tally + 64'd1;

            if (tick_sum >= 64'(model_cfg.stats_window))
            begin
                if (tick_sum == 64'd0)
                begin
                    rate_hold = 64'd0;
                end
                else
                begin
                    num   = frame_tally * 64'(model_cfg.tick_rate);
                    whole = num / tick_sum;
                    rem   = num % tick_sum;
                    if (whole > (64'(RATE_MAX) >> FRAC_BITS))
                    begin
                        rate_hold = 64'(RATE_MAX);
                    end
                    else
                    begin
                        frac      = (rem << FRAC_BITS) / tick_sum;
                        whole     = (whole << FRAC_BITS) + frac;
                        rate_hold = (whole > 64'(RATE_MAX)) ? 64'(RATE_MAX) : whole;
                    end
                end
                tick_sum    = 64'd0;
                frame_tally = 64'd0;
                r.updated   = 1'b1;
            end
        end
        r.raw    = raw[RAW_W-1:0];
        r.smooth = smooth_acc[SMOOTH_W-1:0];
        r.rate   = rate_hold[RATE_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic add_setting(fis_reg_idx_t sel, logic [31:0] val);
        stimulus_row_t row;
        row.is_setting = 1'b1;
        row.sel        = sel;
        row.value      = TS_W'(val);
        row.typed      = 1'b0;
        directed_rows.push_back(row);
    endtask

    task automatic add_frame(logic [TS_W-1:0] ts);
        stimulus_row_t row;
        row.is_setting = 1'b0;
        row.sel        = REG_TICK_RATE;
        row.value      = ts;
        row.typed      = 1'b0;
        directed_rows.push_back(row);
    endtask

    task automatic add_checked_frame(logic [TS_W-1:0] ts, logic [RAW_W-1:0] raw,
                                     logic [SMOOTH_W-1:0] smooth,
                                     logic [RATE_W-1:0] rate, logic updated);
        stimulus_row_t row;
        row.is_setting     = 1'b0;
        row.sel            = REG_TICK_RATE;
        row.value          = ts;
        row.typed          = 1'b1;
        row.want.raw       = raw;
        row.want.smooth    = smooth;
        row.want.rate      = rate;
        row.want.updated   = updated;
        directed_rows.push_back(row);
    endtask

    // A register write: setup cycle, then access cycle. pready is always
    // high, so the register takes the value at the end of the access cycle.
    task automatic write_reg(fis_reg_idx_t sel, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_TICK_RATE:        model_cfg.tick_rate        = val;
            REG_MAX_INTERVAL:     model_cfg.max_interval     = val;
            REG_RELOAD_THRESHOLD: model_cfg.reload_threshold = val;
            REG_FAST_THRESHOLD:   model_cfg.fast_threshold   = val;
            REG_FAST_GAIN:        model_cfg.fast_gain        = val[GAIN_W-1:0];
            REG_SLOW_GAIN:        model_cfg.slow_gain        = val[GAIN_W-1:0];
            REG_STATS_WINDOW:     model_cfg.stats_window     = val;
            REG_INITIAL_INTERVAL: model_cfg.initial_interval = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(fis_cfg_t c);
        write_reg(REG_TICK_RATE,        c.tick_rate);
        write_reg(REG_MAX_INTERVAL,     c.max_interval);
        write_reg(REG_RELOAD_THRESHOLD, c.reload_threshold);
        write_reg(REG_FAST_THRESHOLD,   c.fast_threshold);
        write_reg(REG_FAST_GAIN,        32'(c.fast_gain));
        write_reg(REG_SLOW_GAIN,        32'(c.slow_gain));
        write_reg(REG_STATS_WINDOW,     c.stats_window);
        write_reg(REG_INITIAL_INTERVAL, c.initial_interval);
    endtask

    // Every frame produces exactly one result, so once nothing is expected
    // the block is idle and the registers may be touched.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
    endtask

    // Offers one frame and returns at the edge at which it is accepted. The
    // expectation is either the one typed into the table or the model's.
    task automatic send_frame(logic [TS_W-1:0] ts, bit typed, frame_result_t want);
        int            gap;
        frame_result_t got;
        gap = 0;
        if (!no_idle && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        timestamp <= ts;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        got       = smoother_predict(ts);
        stamp_now = ts;
        expected_frames.push_back(typed ? want : got);
    endtask

    // Register settings scaled around a random frame period, with the odd
    // register left fully random.
    function automatic fis_cfg_t draw_settings();
        fis_cfg_t    c;
        int unsigned scale;
        scale              = $urandom_range(64, 1 << 21);
        c.tick_rate        = scale * $urandom_range(40, 600);
        c.max_interval     = scale * $urandom_range(4, 12);
        c.reload_threshold = scale * $urandom_range(2, 6);
        c.fast_threshold   = (scale * $urandom_range(1, 4)) / 3;
        c.fast_gain        = GAIN_W'($urandom_range(0, 255));
        c.slow_gain        = GAIN_W'($urandom_range(0, 255));
        c.stats_window     = scale * $urandom_range(3, 60);
        c.initial_interval = $urandom();
        if ($urandom_range(0, 3) == 0)
            c.tick_rate = $urandom();
        if ($urandom_range(0, 3) == 0)
            c.max_interval = $urandom();
        if ($urandom_range(0, 5) == 0)
            c.stats_window = $urandom();
        return c;
    endfunction

    // Next timestamp: mostly a regular frame period with jitter, with
    // thresholds, backwards steps and wild jumps mixed in.
    function automatic logic [TS_W-1:0] next_stamp(logic [TS_W-1:0] cur,
                                                    logic [31:0] period);
        logic [63:0] delta;
        logic [63:0] wobble;
        wobble = 64'($urandom_range(0, 2));
        case ($urandom_range(0, 19))
            0:       delta = 64'd0;
            1:       return cur - TS_W'($urandom_range(1, 1 << 20));
            2:       return TS_W'({$urandom(), $urandom()});
            3:       delta = 64'(model_cfg.fast_threshold) + wobble - 64'd1;
            4:       delta = 64'(model_cfg.reload_threshold) + wobble - 64'd1;
            5:       delta = 64'(model_cfg.max_interval) + wobble - 64'd1;
            6:       delta = 64'($urandom());
            default: delta = 64'(period) - 64'(period >> 3)
                             + 64'($urandom_range(0, period >> 2));
        endcase
        return cur + delta[TS_W-1:0];
    endfunction

    // One phase of random frames under one set of register values.
    task automatic run_phase(fis_cfg_t c, int frames, bit quiet, bit squeeze);
        logic [31:0]   period;
        frame_result_t none;
        none = '{default: '0};
        wait_idle();
        load_settings(c);
        no_idle = quiet;
        case ($urandom_range(0, 2))
            0:       period = model_cfg.fast_threshold;
            1:       period = model_cfg.reload_threshold >> 1;
            default: period = $urandom_range(1, model_cfg.reload_threshold);
        endcase
        for (int i = 0; i < frames; i++)
        begin
            // Half way through, the receiver holds off for a long stretch
            // while frames keep coming, so the block backs up.
            if (squeeze && i == frames / 2)
                hold_pending = 1'b1;
            send_frame(next_stamp(stamp_now, period), 1'b0, none);
        end
    endtask

    task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result %0d: %s is %0h, expected %0h",
                     $time, results_checked, field, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Sender: reset, directed table, random phases.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        stimulus_row_t row;
        frame_result_t none;
        fis_cfg_t      c;

        none      = '{default: '0};
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        timestamp <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n     <= 1'b1;

        // Priming with the largest initial interval, at time zero.
        add_setting(REG_INITIAL_INTERVAL, 32'hFFFF_FFFF);
        add_checked_frame(63'd0, 32'hFFFF_FFFF, 40'hFF_FFFF_FF00, 24'd0, 1'b0);
        // Short interval with the fast gain, then a slower one.
        add_frame(63'd16667);
        add_frame(63'd216667);
        // Time runs backwards: the interval is zero.
        add_frame(63'd100);
        // Exactly the maximum interval and therefore a reload.
        add_checked_frame(63'd1000100, 32'd1000000, 40'd256000000, 24'd0, 1'b0);
        add_frame(63'd3000100);
        add_frame(63'd4000100);
        add_frame(63'd5000100);
        // The interval sum crosses the window here and the rate is computed.
        add_frame(63'd6000100);
        add_frame(63'd6010100);
        // Extreme gains: the largest fast step, no slow step at all.
        add_setting(REG_FAST_GAIN, 32'd255);
        add_setting(REG_SLOW_GAIN, 32'd0);
        add_frame(63'd6020100);
        add_frame(63'd6220100);
        // Drive the smoothed value to zero, then let it reload from zero.
        add_setting(REG_RELOAD_THRESHOLD, 32'd0);
        add_frame(63'd6220100);
        add_setting(REG_RELOAD_THRESHOLD, 32'hFFFF_FFFF);
        add_frame(63'd6220105);
        // Zero window: every frame updates the rate, a zero sum gives rate
        // zero, and a sum of one with the largest tick rate saturates.
        add_setting(REG_MAX_INTERVAL, 32'hFFFF_FFFF);
        add_setting(REG_TICK_RATE, 32'hFFFF_FFFF);
        add_setting(REG_STATS_WINDOW, 32'd0);
        add_frame(63'd6220105);
        add_frame(63'd6220105);
        add_frame(63'd6220106);
        // A tick rate of zero gives rate zero; largest timestamp, then wrap.
        add_setting(REG_TICK_RATE, 32'd0);
        add_checked_frame(63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FF00,
                          24'd0, 1'b1);
        add_frame(63'd0);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_setting)
            begin
                wait_idle();
                write_reg(row.sel, row.value[31:0]);
            end
            else
            begin
                send_frame(row.value, row.typed, row.want);
            end
        end

        // Random phases. The fixed settings cover the register extremes.
        run_phase(reset_settings(), 250, 1'b0, 1'b0);
        run_phase(draw_settings(), 250, 1'b0, 1'b1);
        c = '{default: '1};
        run_phase(c, 150, 1'b0, 1'b0);
        c = '{default: '0};
        c.tick_rate = 32'd1;
        run_phase(c, 100, 1'b0, 1'b0);
        run_phase(draw_settings(), 250, 1'b1, 1'b0);
        run_phase(draw_settings(), 250, 1'b0, 1'b0);
        run_phase(draw_settings(), 250, 1'b0, 1'b0);
        run_phase(draw_settings(), 200, 1'b0, 1'b0);

        // The last part of the run goes without idling on either side.
        run_phase(draw_settings(), 200, 1'b1, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("frame_interval_smoother_test: done, clean");
        else
            $display("frame_interval_smoother_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request. The
    // hold-off is counted here so that the sender carries on regardless.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: each accepted result transaction against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_frames.size() == 0)
            begin
                flag_mismatch("unexpected result, raw_interval", 64'(raw_interval), 64'd0);
            end
            else
            begin
                want = expected_frames.pop_front();
                if (raw_interval !== want.raw)
                    flag_mismatch("raw_interval", 64'(raw_interval), 64'(want.raw));
                if (smoothed_interval !== want.smooth)
                    flag_mismatch("smoothed_interval", 64'(smoothed_interval),
                                  64'(want.smooth));
                if (frame_rate !== want.rate)
                    flag_mismatch("frame_rate", 64'(frame_rate), 64'(want.rate));
                if (rate_updated !== want.updated)
                    flag_mismatch("rate_updated", 64'(rate_updated), 64'(want.updated));
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when nothing moves on any port for too long.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("frame_interval_smoother_test: done, errors");
                $finish;
            end
        end
    end

endmodule
